// ===== rtl/kmp_pkg.sv =====
package kmp_pkg;

   localparam int BYTE_BITS  = 8;
   localparam int CSR_BITS   = 64;
   localparam int LEN_BITS   = 5;
   localparam int START_BITS = 16;

   typedef enum logic [1:0] {
      CSR_PATTERN_LENGTH = 2'd0,
      CSR_PATTERN_LOW    = 2'd1,
      CSR_PATTERN_HIGH   = 2'd2,
      CSR_UNUSED         = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_SEARCHING       = 2'd0,
      ST_MATCH_HERE      = 2'd1,
      ST_MATCHED_EARLIER = 2'd2,
      ST_NO_MATCH        = 2'd3
   } status_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] text_byte;
      logic                 first_of_text;
      logic                 last_of_text;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [START_BITS-1:0] match_start;
   } rsp_type;

   typedef struct packed {
      logic advance;   // byte transfer taken this cycle
      logic flush;     // pattern register written, drop partial matches
      logic keep;      // this prefix length is shorter than the pattern
   } cell_ctrl_type;

endpackage

// ===== rtl/kmp_cell.sv =====
module kmp_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  kmp_pkg::cell_ctrl_type        ctrl,
   input  logic                          prev_alive,
   input  logic [kmp_pkg::BYTE_BITS-1:0] pattern_byte,
   input  logic [kmp_pkg::BYTE_BITS-1:0] text_byte,
   output logic                          hit,
   output logic                          alive
);
   import kmp_pkg::*;

   logic alive_ff;
   logic alive_in;

   // prefix k matches after this byte if prefix k-1 matched before it and the byte equals pattern byte k
   assign hit = prev_alive & (pattern_byte == text_byte);

   always_comb begin
      if (ctrl.flush) begin
         alive_in = 1'b0;
      end else if (ctrl.advance) begin
         alive_in = hit & ctrl.keep;
      end else begin
         alive_in = alive_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff <= 1'b0;
      end else begin
         alive_ff <= alive_in;
      end
   end

   assign alive = alive_ff;

endmodule

// ===== rtl/kmp_stream_pattern_matcher.sv =====
// Streaming first-occurrence matcher for a pattern of up to MAX_PATTERN bytes. Text enters
// one byte per transfer and every byte gives one status transfer; a byte can be taken in
// every cycle unless a held status is stalled, and its status is written to the output
// register in the cycle after. A row of MAX_PATTERN cells, one per prefix length, each
// remembers whether that prefix ends at the last byte seen and hands that flag to the
// next cell, so the whole fallback chain is updated at once across the row. Writing any
// pattern register drops partial matches but keeps the position and any match already
// found. Positions saturate at 2^POSITION_BITS-1; match_start carries their low 16 bits.
module kmp_stream_pattern_matcher #(
   parameter int MAX_PATTERN   = 16,
   parameter int POSITION_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  kmp_pkg::req_type             req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output kmp_pkg::rsp_type             rsp_payload,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [1:0]                   csr_index,
   input  logic [kmp_pkg::CSR_BITS-1:0] csr_data
);
   import kmp_pkg::*;

   localparam int LW = $clog2(MAX_PATTERN + 1);
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   logic [LEN_BITS-1:0]      pattern_length_ff;
   logic [CSR_BITS-1:0]      pattern_low_ff;
   logic [CSR_BITS-1:0]      pattern_high_ff;
   logic [2*CSR_BITS-1:0]    pattern_all;
   logic                     csr_write;
   logic [LW-1:0]            n_eff;

   logic [POSITION_BITS-1:0] position_ff;
   logic [POSITION_BITS-1:0] position_in;
   logic [POSITION_BITS-1:0] position_cur;
   logic [POSITION_BITS-1:0] start_pos;
   logic                     found_ff;
   logic                     found_in;
   logic [START_BITS-1:0]    found_start_ff;
   logic [START_BITS-1:0]    found_start_in;
   logic                     found_cur;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   rsp_type                  rsp_ff;
   rsp_type                  rsp_in;
   rsp_type                  result;

   logic                     accept;
   logic                     match;
   logic [MAX_PATTERN:0]     hit_vec;
   logic [MAX_PATTERN:0]     alive_vec;
   logic [MAX_PATTERN:0]     keep_vec;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready &
                      ((csr_index == CSR_PATTERN_LENGTH) || (csr_index == CSR_PATTERN_LOW) ||
                       (csr_index == CSR_PATTERN_HIGH));

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_data[LEN_BITS-1:0];
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr_data;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_data;
            default:            ;
         endcase
      end
   end

   assign pattern_all = {pattern_high_ff, pattern_low_ff};
   assign n_eff = (pattern_length_ff > LEN_BITS'(MAX_PATTERN)) ? LW'(MAX_PATTERN)
                                                               : LW'(pattern_length_ff);

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign hit_vec[0]   = 1'b0;
   assign alive_vec[0] = 1'b1;
   assign keep_vec[0]  = 1'b1;

   for (genvar k = 1; k <= MAX_PATTERN; k++) begin : g_cell
      cell_ctrl_type ctrl;
      logic          prev;

      assign keep_vec[k]  = LW'(k) < n_eff;
      assign ctrl.advance = accept;
      assign ctrl.flush   = csr_write;
      assign ctrl.keep    = keep_vec[k];
      // the empty prefix always matches; longer ones are void on a restart
      if (k == 1) begin : g_head
         assign prev = 1'b1;
      end else begin : g_body
         assign prev = alive_vec[k-1] & ~req_payload.first_of_text;
      end

      kmp_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .prev_alive   (prev),
         .pattern_byte (pattern_all[BYTE_BITS*(k-1) +: BYTE_BITS]),
         .text_byte    (req_payload.text_byte),
         .hit          (hit_vec[k]),
         .alive        (alive_vec[k])
      );
   end

   assign match        = hit_vec[n_eff];
   assign found_cur    = found_ff & ~req_payload.first_of_text;
   assign position_cur = req_payload.first_of_text ? '0 : position_ff;
   assign start_pos    = position_cur + POSITION_BITS'(1) - POSITION_BITS'(n_eff);

   always_comb begin
      result         = '{status: ST_SEARCHING, match_start: '0};
      found_in       = found_cur;
      found_start_in = req_payload.first_of_text ? '0 : found_start_ff;
      if (found_cur) begin
         result.status      = ST_MATCHED_EARLIER;
         result.match_start = found_start_ff;
      end else if ((n_eff != '0) && match) begin
         result.status      = ST_MATCH_HERE;
         result.match_start = START_BITS'(start_pos);
         found_in           = 1'b1;
         found_start_in     = START_BITS'(start_pos);
      end else if (req_payload.last_of_text) begin
         result.status = ST_NO_MATCH;
      end
      position_in = (position_cur == POS_MAX) ? position_cur
                                              : position_cur + POSITION_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         found_ff       <= 1'b0;
         found_start_ff <= '0;
      end else if (accept) begin
         position_ff    <= position_in;
         found_ff       <= found_in;
         found_start_ff <= found_start_in;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   // no partial match may be held for a prefix as long as the pattern or longer
   a_alive_below_length: assert property (@(posedge clock) disable iff (reset)
      (alive_vec & ~keep_vec) == '0)
      else $error("prefix flag set at or beyond pattern length");

   // once a match is stored, every byte up to a restart reports it
   a_found_sticky: assert property (@(posedge clock) disable iff (reset)
      accept && found_ff && !req_payload.first_of_text
      |=> rsp_valid_ff && (rsp_ff.status == ST_MATCHED_EARLIER))
      else $error("stored match not reported");

   // a held status is only dropped once it has been taken
   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) |-> !$past(rsp_stall))
      else $error("status dropped while stalled");
`endif

endmodule
